[src/tpc_pkg.sv]
`timescale 1ns / 1ps
// tpc_pkg: shared types, constants and palette rom for the thermal pixel colormap
package tpc_pkg;

  localparam int PixelBits = 16;
  localparam int LevelBits = 16;
  localparam int SpanBits = LevelBits + 1;
  localparam int IdxBits = 8;
  localparam int DivSteps = IdxBits;
  localparam int CfgIdxBits = 4;

  localparam logic [LevelBits-1:0] PixelMask = LevelBits'((32'd1 << PixelBits) - 32'd1);
  localparam logic [LevelBits-1:0] MinReset = '0;
  localparam logic [LevelBits-1:0] MaxReset = '1;
  localparam logic [IdxBits-1:0] IdxLow = '0;
  localparam logic [IdxBits-1:0] IdxHigh = '1;

  localparam logic [CfgIdxBits-1:0] CfgMinLevel = CfgIdxBits'(0);
  localparam logic [CfgIdxBits-1:0] CfgMaxLevel = CfgIdxBits'(1);

  typedef struct packed {
    logic [LevelBits-1:0] rem;
    logic [SpanBits-1:0]  dvs;
    logic [IdxBits-1:0]   quo;
    logic                 clip;
  } tpc_div_t;

  function automatic logic [23:0] hot_rgb(input logic [6:0] i);
    logic [23:0] rgb;
    case (i)
      7'd0: rgb = {8'd0, 8'd0, 8'd9};
      7'd1: rgb = {8'd2, 8'd0, 8'd16};
      7'd2: rgb = {8'd4, 8'd0, 8'd24};
      7'd3: rgb = {8'd6, 8'd0, 8'd31};
      7'd4: rgb = {8'd8, 8'd0, 8'd38};
      7'd5: rgb = {8'd10, 8'd0, 8'd45};
      7'd6: rgb = {8'd12, 8'd0, 8'd53};
      7'd7: rgb = {8'd14, 8'd0, 8'd60};
      7'd8: rgb = {8'd17, 8'd0, 8'd67};
      7'd9: rgb = {8'd19, 8'd0, 8'd74};
      7'd10: rgb = {8'd21, 8'd0, 8'd82};
      7'd11: rgb = {8'd23, 8'd0, 8'd89};
      7'd12: rgb = {8'd25, 8'd0, 8'd96};
      7'd13: rgb = {8'd27, 8'd0, 8'd103};
      7'd14: rgb = {8'd29, 8'd0, 8'd111};
      7'd15: rgb = {8'd31, 8'd0, 8'd118};
      7'd16: rgb = {8'd36, 8'd0, 8'd120};
      7'd17: rgb = {8'd41, 8'd0, 8'd121};
      7'd18: rgb = {8'd46, 8'd0, 8'd122};
      7'd19: rgb = {8'd51, 8'd0, 8'd123};
      7'd20: rgb = {8'd56, 8'd0, 8'd124};
      7'd21: rgb = {8'd61, 8'd0, 8'd125};
      7'd22: rgb = {8'd66, 8'd0, 8'd126};
      7'd23: rgb = {8'd71, 8'd0, 8'd127};
      7'd24: rgb = {8'd76, 8'd1, 8'd128};
      7'd25: rgb = {8'd81, 8'd1, 8'd129};
      7'd26: rgb = {8'd86, 8'd1, 8'd130};
      7'd27: rgb = {8'd91, 8'd1, 8'd131};
      7'd28: rgb = {8'd96, 8'd1, 8'd132};
      7'd29: rgb = {8'd101, 8'd1, 8'd133};
      7'd30: rgb = {8'd106, 8'd1, 8'd134};
      7'd31: rgb = {8'd111, 8'd1, 8'd135};
      7'd32: rgb = {8'd116, 8'd1, 8'd136};
      7'd33: rgb = {8'd121, 8'd1, 8'd136};
      7'd34: rgb = {8'd125, 8'd2, 8'd137};
      7'd35: rgb = {8'd130, 8'd2, 8'd137};
      7'd36: rgb = {8'd135, 8'd3, 8'd137};
      7'd37: rgb = {8'd139, 8'd3, 8'd138};
      7'd38: rgb = {8'd144, 8'd3, 8'd138};
      7'd39: rgb = {8'd149, 8'd4, 8'd138};
      7'd40: rgb = {8'd153, 8'd4, 8'd139};
      7'd41: rgb = {8'd158, 8'd5, 8'd139};
      7'd42: rgb = {8'd163, 8'd5, 8'd139};
      7'd43: rgb = {8'd167, 8'd5, 8'd140};
      7'd44: rgb = {8'd172, 8'd6, 8'd140};
      7'd45: rgb = {8'd177, 8'd6, 8'd140};
      7'd46: rgb = {8'd181, 8'd7, 8'd141};
      7'd47: rgb = {8'd186, 8'd7, 8'd141};
      7'd48: rgb = {8'd189, 8'd10, 8'd137};
      7'd49: rgb = {8'd191, 8'd13, 8'd132};
      7'd50: rgb = {8'd194, 8'd16, 8'd127};
      7'd51: rgb = {8'd196, 8'd19, 8'd121};
      7'd52: rgb = {8'd198, 8'd22, 8'd116};
      7'd53: rgb = {8'd200, 8'd25, 8'd111};
      7'd54: rgb = {8'd203, 8'd28, 8'd106};
      7'd55: rgb = {8'd205, 8'd31, 8'd101};
      7'd56: rgb = {8'd207, 8'd34, 8'd95};
      7'd57: rgb = {8'd209, 8'd37, 8'd90};
      7'd58: rgb = {8'd212, 8'd40, 8'd85};
      7'd59: rgb = {8'd214, 8'd43, 8'd80};
      7'd60: rgb = {8'd216, 8'd46, 8'd75};
      7'd61: rgb = {8'd218, 8'd49, 8'd69};
      7'd62: rgb = {8'd221, 8'd52, 8'd64};
      7'd63: rgb = {8'd223, 8'd55, 8'd59};
      7'd64: rgb = {8'd224, 8'd57, 8'd49};
      7'd65: rgb = {8'd225, 8'd60, 8'd47};
      7'd66: rgb = {8'd226, 8'd64, 8'd44};
      7'd67: rgb = {8'd227, 8'd67, 8'd42};
      7'd68: rgb = {8'd228, 8'd71, 8'd39};
      7'd69: rgb = {8'd229, 8'd74, 8'd37};
      7'd70: rgb = {8'd230, 8'd78, 8'd34};
      7'd71: rgb = {8'd231, 8'd81, 8'd32};
      7'd72: rgb = {8'd231, 8'd85, 8'd29};
      7'd73: rgb = {8'd232, 8'd88, 8'd27};
      7'd74: rgb = {8'd233, 8'd92, 8'd24};
      7'd75: rgb = {8'd234, 8'd95, 8'd22};
      7'd76: rgb = {8'd235, 8'd99, 8'd19};
      7'd77: rgb = {8'd236, 8'd102, 8'd17};
      7'd78: rgb = {8'd237, 8'd106, 8'd14};
      7'd79: rgb = {8'd238, 8'd109, 8'd12};
      7'd80: rgb = {8'd239, 8'd112, 8'd12};
      7'd81: rgb = {8'd240, 8'd116, 8'd12};
      7'd82: rgb = {8'd240, 8'd119, 8'd12};
      7'd83: rgb = {8'd241, 8'd123, 8'd12};
      7'd84: rgb = {8'd241, 8'd127, 8'd12};
      7'd85: rgb = {8'd242, 8'd130, 8'd12};
      7'd86: rgb = {8'd242, 8'd134, 8'd12};
      7'd87: rgb = {8'd243, 8'd138, 8'd12};
      7'd88: rgb = {8'd243, 8'd141, 8'd13};
      7'd89: rgb = {8'd244, 8'd145, 8'd13};
      7'd90: rgb = {8'd244, 8'd149, 8'd13};
      7'd91: rgb = {8'd245, 8'd152, 8'd13};
      7'd92: rgb = {8'd245, 8'd156, 8'd13};
      7'd93: rgb = {8'd246, 8'd160, 8'd13};
      7'd94: rgb = {8'd246, 8'd163, 8'd13};
      7'd95: rgb = {8'd247, 8'd167, 8'd13};
      7'd96: rgb = {8'd247, 8'd171, 8'd13};
      7'd97: rgb = {8'd248, 8'd175, 8'd14};
      7'd98: rgb = {8'd248, 8'd178, 8'd15};
      7'd99: rgb = {8'd249, 8'd182, 8'd16};
      7'd100: rgb = {8'd249, 8'd185, 8'd18};
      7'd101: rgb = {8'd250, 8'd189, 8'd19};
      7'd102: rgb = {8'd250, 8'd192, 8'd20};
      7'd103: rgb = {8'd251, 8'd196, 8'd21};
      7'd104: rgb = {8'd251, 8'd199, 8'd22};
      7'd105: rgb = {8'd252, 8'd203, 8'd23};
      7'd106: rgb = {8'd252, 8'd206, 8'd24};
      7'd107: rgb = {8'd253, 8'd210, 8'd25};
      7'd108: rgb = {8'd253, 8'd213, 8'd27};
      7'd109: rgb = {8'd254, 8'd217, 8'd28};
      7'd110: rgb = {8'd254, 8'd220, 8'd29};
      7'd111: rgb = {8'd255, 8'd224, 8'd30};
      7'd112: rgb = {8'd255, 8'd227, 8'd39};
      7'd113: rgb = {8'd255, 8'd229, 8'd53};
      7'd114: rgb = {8'd255, 8'd231, 8'd67};
      7'd115: rgb = {8'd255, 8'd233, 8'd81};
      7'd116: rgb = {8'd255, 8'd234, 8'd95};
      7'd117: rgb = {8'd255, 8'd236, 8'd109};
      7'd118: rgb = {8'd255, 8'd238, 8'd123};
      7'd119: rgb = {8'd255, 8'd240, 8'd137};
      7'd120: rgb = {8'd255, 8'd242, 8'd151};
      7'd121: rgb = {8'd255, 8'd244, 8'd165};
      7'd122: rgb = {8'd255, 8'd246, 8'd179};
      7'd123: rgb = {8'd255, 8'd248, 8'd193};
      7'd124: rgb = {8'd255, 8'd249, 8'd207};
      7'd125: rgb = {8'd255, 8'd251, 8'd221};
      7'd126: rgb = {8'd255, 8'd253, 8'd235};
      default: rgb = {8'd255, 8'd255, 8'd249};
    endcase
    return rgb;
  endfunction

  // lower half is a gray ramp, upper half the hot ramp
  function automatic logic [23:0] palette_rgb(input logic [IdxBits-1:0] idx);
    logic [7:0]  g;
    logic [7:0]  dbl;
    logic [23:0] rgb;
    dbl = {idx[6:0], 1'b0};
    g = idx[6] ? (8'd254 - dbl) : (8'd255 - dbl);
    if (idx[7]) begin
      rgb = hot_rgb(idx[6:0]);
    end else begin
      rgb = {g, g, g};
    end
    return rgb;
  endfunction

endpackage

[src/tpc_front.sv]
`timescale 1ns / 1ps
// tpc_front: range check, clamping and divider setup stage
module tpc_front
  import tpc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic [LevelBits-1:0] raw_pixel_i,
  input  logic [LevelBits-1:0] min_level_i,
  input  logic [LevelBits-1:0] max_level_i,
  output logic                 vld_o,
  output tpc_div_t             data_o
);

  logic [LevelBits-1:0] pix;
  logic                 inv;
  logic                 below;
  logic                 above;
  logic                 vld_q;
  tpc_div_t             data_d;
  tpc_div_t             data_q;

  always_comb begin
    pix = raw_pixel_i & PixelMask;
    inv = max_level_i < min_level_i;
    below = pix < min_level_i;
    above = pix > max_level_i;
    data_d.clip = inv | below | above;
    data_d.quo = (above && !inv && !below) ? IdxHigh : IdxLow;
    data_d.rem = pix - min_level_i;
    data_d.dvs = {1'b0, max_level_i} - {1'b0, min_level_i} + SpanBits'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign vld_o = vld_q;
  assign data_o = data_q;

endmodule

[src/tpc_div_stage.sv]
`timescale 1ns / 1ps
// tpc_div_stage: one restoring division step producing one index bit
module tpc_div_stage
  import tpc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     vld_i,
  input  tpc_div_t data_i,
  output logic     vld_o,
  output tpc_div_t data_o
);

  logic [SpanBits-1:0] sh;
  logic                ge;
  logic                vld_q;
  tpc_div_t            data_d;
  tpc_div_t            data_q;

  always_comb begin
    sh = {data_i.rem, 1'b0};
    ge = sh >= data_i.dvs;
    data_d = data_i;
    if (!data_i.clip) begin
      data_d.rem = ge ? LevelBits'(sh - data_i.dvs) : sh[LevelBits-1:0];
      data_d.quo = {data_i.quo[IdxBits-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign vld_o = vld_q;
  assign data_o = data_q;

  // partial remainder stays below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !data_q.clip) |-> (data_q.rem < data_q.dvs))
    else $error("tpc_div_stage: remainder not below divisor");

  // clamped index passes untouched
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_i && data_i.clip) |=> (data_q.clip && data_q.quo == $past(data_i.quo)))
    else $error("tpc_div_stage: clamped index changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_i |=> (vld_q && data_q.dvs == $past(data_i.dvs)))
    else $error("tpc_div_stage: word lost or divisor changed");

endmodule

[src/tpc_palette.sv]
`timescale 1ns / 1ps
// tpc_palette: palette rom lookup and output register
module tpc_palette
  import tpc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vld_i,
  input  tpc_div_t   data_i,
  output logic       valid_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic       clipped_o
);

  logic [23:0] rgb_d;
  logic [23:0] rgb_q;
  logic        clip_q;
  logic        valid_q;

  assign rgb_d = palette_rgb(data_i.quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
    clip_q <= data_i.clip;
  end

  assign valid_o = valid_q;
  assign red_o = rgb_q[23:16];
  assign green_o = rgb_q[15:8];
  assign blue_o = rgb_q[7:0];
  assign clipped_o = clip_q;

endmodule

[src/thermal_pixel_colormap.sv]
`timescale 1ns / 1ps
// thermal_pixel_colormap: top level, config registers and pipeline assembly
//
// A raw pixel word is taken on raw_pixel_i at every clock edge where start_i
// is high and busy_o is low. busy_o is always low, so one pixel can enter in
// every cycle. Each pixel yields one color word on red_o, green_o, blue_o and
// clipped_o, marked by valid_o for a single cycle, once the pixel has passed
// through the pipeline registers: one range check stage, eight
// restoring division stages (one index bit each) and one palette stage.
// Words leave in the order they came in. The receiver cannot stall the block.
// min_level and max_level are written over the cfg channel (index 0 and 1,
// cfg_ready_o always high); writes to other indexes are dropped. Write them
// only while no pixel is in flight. Reset clears the pipeline valid bits and
// sets the range to the full 16-bit scale.
module thermal_pixel_colormap
  import tpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [LevelBits-1:0]  raw_pixel_i,
  output logic                  valid_o,
  output logic [7:0]            red_o,
  output logic [7:0]            green_o,
  output logic [7:0]            blue_o,
  output logic                  clipped_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [LevelBits-1:0]  cfg_data_i
);

  logic [LevelBits-1:0] min_level_q;
  logic [LevelBits-1:0] max_level_q;
  logic                 vld_s [DivSteps+1];
  tpc_div_t             data_s [DivSteps+1];

  assign busy_o = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_level_q <= MinReset;
      max_level_q <= MaxReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgMinLevel: min_level_q <= cfg_data_i;
        CfgMaxLevel: max_level_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (start_i && !busy_o),
    .raw_pixel_i (raw_pixel_i),
    .min_level_i (min_level_q),
    .max_level_i (max_level_q),
    .vld_o       (vld_s[0]),
    .data_o      (data_s[0])
  );

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    tpc_div_stage u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld_s[k]),
      .data_i (data_s[k]),
      .vld_o  (vld_s[k+1]),
      .data_o (data_s[k+1])
    );
  end

  tpc_palette u_palette (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vld_i     (vld_s[DivSteps]),
    .data_i    (data_s[DivSteps]),
    .valid_o   (valid_o),
    .red_o     (red_o),
    .green_o   (green_o),
    .blue_o    (blue_o),
    .clipped_o (clipped_o)
  );

endmodule
